// File: rtl/ticks_to_nanoseconds_top_defines.svh
// Assertion macros shared by the checker of the tick to nanosecond converter.
// Depends on nothing; the including scope provides i_clk and i_rst_n.
`ifndef TICKS_TO_NANOSECONDS_TOP_DEFINES_SVH
`define TICKS_TO_NANOSECONDS_TOP_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define TTN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define TTN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/ttn_pkg.sv
// Shared constants for the tick to nanosecond converter.
// Depends on nothing; used by every module of the block.
package ttn_pkg;

    // Bits needed to hold one billion.
    localparam int NS_WIDTH = 30;
    localparam logic [NS_WIDTH-1:0] NS_PER_SECOND = NS_WIDTH'(1000000000);

    // Fixed widths of the beats and the configuration word.
    localparam int TICK_PORT_W = 64;
    localparam int OUT_WIDTH   = 64;
    localparam int RATE_PORT_W = 32;
    localparam logic [RATE_PORT_W-1:0] RATE_RESET = 32'd19200000;

endpackage

// File: rtl/ttn_mul.sv
// Front end: scales the tick count by one billion in two registered stages.
// Depends on ttn_pkg.
module ttn_mul
    import ttn_pkg::*;
#(
    parameter int TICK_WIDTH = 64,
    parameter int DW         = TICK_WIDTH + NS_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [TICK_WIDTH-1:0] i_ticks,
    output logic                  o_valid,
    output logic [DW-1:0]         o_dividend
);

    localparam int LO_W = TICK_WIDTH / 2;
    localparam int HI_W = TICK_WIDTH - LO_W;
    localparam int LP_W = LO_W + NS_WIDTH;
    localparam int HP_W = HI_W + NS_WIDTH;

    logic            r_prod_valid;
    logic [LP_W-1:0] r_lo_prod;
    logic [HP_W-1:0] r_hi_prod;
    logic            r_valid;
    logic [DW-1:0]   r_dividend;

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_valid      <= 1'b0;
        end else if (i_en) begin
            r_prod_valid <= i_valid;
            r_valid      <= r_prod_valid;
        end
    end

    // Two half-width products, then their sum with the high half shifted up.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo_prod  <= LP_W'(i_ticks[LO_W-1:0]) * LP_W'(NS_PER_SECOND);
            r_hi_prod  <= HP_W'(i_ticks[TICK_WIDTH-1:LO_W]) * HP_W'(NS_PER_SECOND);
            r_dividend <= (DW'(r_hi_prod) << LO_W) + DW'(r_lo_prod);
        end
    end

    assign o_valid    = r_valid;
    assign o_dividend = r_dividend;

endmodule

// File: rtl/ttn_cell.sv
// One step of the restoring divider: takes in one dividend bit, yields one quotient bit.
// Depends on ttn_pkg.
module ttn_cell
    import ttn_pkg::*;
#(
    parameter int RATE_WIDTH = 32,
    parameter int DW         = 94
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [RATE_WIDTH-1:0] i_rate,
    input  logic                  i_valid,
    input  logic [RATE_WIDTH-1:0] i_rem,
    input  logic [DW-1:0]         i_work,
    output logic                  o_valid,
    output logic [RATE_WIDTH-1:0] o_rem,
    output logic [DW-1:0]         o_work
);

    logic                  r_valid;
    logic [RATE_WIDTH-1:0] r_rem;
    logic [DW-1:0]         r_work;
    logic [RATE_WIDTH:0]   partial;
    logic [RATE_WIDTH+1:0] diff;
    logic                  fits;
    logic [RATE_WIDTH-1:0] n_rem;
    logic [DW-1:0]         n_work;

    // The work word carries unread dividend bits at the top and quotient bits at the bottom.
    always_comb begin
        partial = {i_rem, i_work[DW-1]};
        diff    = {1'b0, partial} - {2'b00, i_rate};
        fits    = !diff[RATE_WIDTH+1];
        n_rem   = fits ? diff[RATE_WIDTH-1:0] : partial[RATE_WIDTH-1:0];
        n_work  = {i_work[DW-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_work  = r_work;

endmodule

// File: rtl/ticks_to_nanoseconds_top.sv
// Tick count to nanosecond converter, top level.
// Depends on ttn_pkg, ttn_mul and ttn_cell.
//
// Use: a tick count arrives as a beat on the s_axis channel and leaves as
// elapsed nanoseconds on the m_axis channel, one result beat for every input
// beat, in order. The counter frequency in hertz is written through
// i_cfg_wen / i_cfg_wdata while no beat is in flight; a frequency of zero
// gives a result of zero.
// The result is floor(ticks * 10^9 / rate), taken modulo 2^64, which equals
// whole seconds times 10^9 plus the truncated sub-second nanoseconds.
// The scaling by one billion is split into two half-width products and their sum,
// then a row of divider cells yields the quotient, one cell per quotient bit.
// Throughput is one beat per cycle unless the receiver stalls; every cell works
// on a different beat. The last cell's register is the output register. When
// the receiver stalls, the whole row holds and s_axis_tready falls in the same
// cycle; it rises again as soon as the waiting result is taken.
// Reset clears every valid bit, so no result beat appears after reset, and
// loads the frequency register with 19.2 MHz.
module ticks_to_nanoseconds_top
    import ttn_pkg::*;
#(
    parameter int TICK_WIDTH = 64,
    parameter int RATE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wen,
    input  logic [RATE_PORT_W-1:0] i_cfg_wdata,   // tick_rate_hz
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TICK_PORT_W-1:0] s_axis_tdata,  // [63:0] tick_count
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_WIDTH-1:0]   m_axis_tdata   // [63:0] nanoseconds
);

    // Dividend width: the tick count scaled by one billion.
    localparam int DW = TICK_WIDTH + NS_WIDTH;

    logic [RATE_WIDTH-1:0] r_rate;
    logic                  en;
    logic                  rate_zero;

    // Node k feeds cell k; node DW is the output of the last cell.
    logic                  node_valid [DW+1];
    logic [RATE_WIDTH-1:0] node_rem   [DW+1];
    logic [DW-1:0]         node_work  [DW+1];

    // Frequency register; only the low RATE_WIDTH bits are kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_WIDTH'(RATE_RESET);
        end else if (i_cfg_wen) begin
            r_rate <= i_cfg_wdata[RATE_WIDTH-1:0];
        end
    end

    // The row moves as one unless a finished result is waiting to be taken.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    ttn_mul #(
        .TICK_WIDTH (TICK_WIDTH),
        .DW         (DW)
    ) u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (s_axis_tvalid),
        .i_ticks    (s_axis_tdata[TICK_WIDTH-1:0]),
        .o_valid    (node_valid[0]),
        .o_dividend (node_work[0])
    );

    // The partial remainder starts at zero for every beat.
    assign node_rem[0] = '0;

    for (genvar k = 0; k < DW; k++) begin : g_cell
        ttn_cell #(
            .RATE_WIDTH (RATE_WIDTH),
            .DW         (DW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_rate  (r_rate),
            .i_valid (node_valid[k]),
            .i_rem   (node_rem[k]),
            .i_work  (node_work[k]),
            .o_valid (node_valid[k+1]),
            .o_rem   (node_rem[k+1]),
            .o_work  (node_work[k+1])
        );
    end

    // Beats in flight need a steady frequency; the user keeps it, the block does not
    // enforce it. The zero case is decided at the output; the last cell's remainder is unused.
    assign rate_zero     = (r_rate == '0);
    assign m_axis_tvalid = node_valid[DW];
    assign m_axis_tdata  = rate_zero ? '0 : OUT_WIDTH'(node_work[DW]);

endmodule

// File: rtl/ttn_checker.sv
// Port-level checks for the tick to nanosecond converter, bound to the top level.
// Depends on ttn_pkg and ticks_to_nanoseconds_top_defines.svh.
`include "ticks_to_nanoseconds_top_defines.svh"

module ttn_checker
    import ttn_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_WIDTH-1:0]   m_axis_tdata
);

    // A stalled result beat keeps its value.
    `TTN_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

    // While a result waits, no new tick count may enter the row.
    `TTN_ASSERT(a_stall_blocks_in, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken while output stalled")

    // With no result waiting, the block always takes input.
    `TTN_ASSERT(a_ready_when_free, !m_axis_tvalid |-> s_axis_tready, "input refused with output free")

    // Nothing is shown in the cycle after reset.
    `TTN_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !m_axis_tvalid, "result beat right after reset")

endmodule

bind ticks_to_nanoseconds_top ttn_checker u_ttn_checker (.*);
